/* sv/gcct_pkg.sv */
// shared types and constants for the gc collection trigger policy
`timescale 1ns / 1ps

package gcct_pkg;

  // field widths
  localparam int unsigned BYTES_W = 40;
  localparam int unsigned CNT_W   = 31;
  localparam int unsigned PCT_W   = 10;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 31;

  // default arena size in bytes
  localparam longint unsigned ARENA_BYTES_DEF = 64'd1048576;

  // percent used when the register holds zero
  localparam logic [PCT_W-1:0] PCT_FALLBACK = PCT_W'(50);

  // event codes
  typedef enum logic [OP_W-1:0] {
    OP_YOUNG_ALLOC   = 3'd0,
    OP_OLD_ALLOC     = 3'd1,
    OP_AFTER_MINOR   = 3'd2,
    OP_ALLOC_FAIL    = 3'd3,
    OP_SET_FOOTPRINT = 3'd4
  } op_t;

  // decision codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE         = 3'd0,
    ACT_MINOR_EVERYN = 3'd1,
    ACT_FULL_GROWTH  = 3'd2,
    ACT_FULL_EVERYN  = 3'd3,
    ACT_FULL_PROMO   = 3'd4,
    ACT_FULL_FAIL    = 3'd5
  } action_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_DISABLED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NURSERY_ON       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVERY_N_ALLOCS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_PERCENT   = 8'd3;

  // configuration registers
  typedef struct packed {
    logic             collect_disabled;
    logic             nursery_on;
    logic [CNT_W-1:0] every_n_allocs;
    logic [PCT_W-1:0] growth_percent;
  } gc_cfg_t;

  // policy state
  typedef struct packed {
    logic [BYTES_W-1:0] old_bytes_total;
    logic [BYTES_W-1:0] old_bytes_at_full;
    logic [CNT_W-1:0]   alloc_counter;
    logic [BYTES_W-1:0] footprint_at_full;
  } gc_state_t;

endpackage

/* sv/gcct_decide.sv */
// combinational decision and next-state logic for one allocator event
`timescale 1ns / 1ps

module gcct_decide import gcct_pkg::*; #(
  parameter longint unsigned ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  op_t                op,
  input  logic [BYTES_W-1:0] alloc_bytes,
  input  logic [BYTES_W-1:0] footprint_bytes,
  input  gc_cfg_t            cfg,
  input  gc_state_t          cur,
  output gc_state_t          nxt,
  output action_t            action
);

  localparam logic [BYTES_W-1:0] FLOOR_BYTES = BYTES_W'(ARENA_BYTES) << 1;
  localparam int unsigned PROD_W = BYTES_W + PCT_W;

  logic [CNT_W-1:0]   cnt_inc;
  logic [BYTES_W:0]   sum;
  logic [BYTES_W-1:0] total_sat;
  logic [BYTES_W-1:0] total_eff;
  logic [BYTES_W-1:0] growth;
  logic [PCT_W-1:0]   pct_eff;
  logic [PROD_W-1:0]  fp_prod;
  logic [PROD_W-1:0]  growth_x100;
  logic               reached;
  logic               cadence;

  // counting and saturating byte add
  assign cnt_inc   = cur.alloc_counter + CNT_W'(1);
  assign sum       = {1'b0, cur.old_bytes_total} + {1'b0, alloc_bytes};
  assign total_sat = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
  assign total_eff = (op == OP_OLD_ALLOC) ? total_sat : cur.old_bytes_total;

  // growth since last full collection, floored at zero
  assign growth = (total_eff >= cur.old_bytes_at_full) ?
                  total_eff - cur.old_bytes_at_full : '0;

  // growth >= floor(fp*pct/100)  <=>  growth*100 + 99 >= fp*pct
  assign pct_eff     = (cfg.growth_percent == '0) ? PCT_FALLBACK : cfg.growth_percent;
  assign fp_prod     = PROD_W'(cur.footprint_at_full) * PROD_W'(pct_eff);
  assign growth_x100 = PROD_W'(growth) * PROD_W'(100) + PROD_W'(99);
  assign reached     = (growth_x100 >= fp_prod) && (growth >= FLOOR_BYTES);

  // stress cadence against the incremented count
  assign cadence = (cfg.every_n_allocs != '0) && (cfg.every_n_allocs == cnt_inc);

  // per-event update
  always_comb begin
    nxt    = cur;
    action = ACT_NONE;
    case (op)
      OP_YOUNG_ALLOC: begin
        nxt.alloc_counter = cnt_inc;
        if (!cfg.collect_disabled && cadence) begin
          nxt.alloc_counter = '0;
          action            = ACT_MINOR_EVERYN;
        end
      end
      OP_OLD_ALLOC: begin
        nxt.alloc_counter   = cnt_inc;
        nxt.old_bytes_total = total_sat;
        if (!cfg.collect_disabled) begin
          if (reached) begin
            action = ACT_FULL_GROWTH;
          end else if (!cfg.nursery_on && cadence) begin
            action = ACT_FULL_EVERYN;
          end
          if (reached || (!cfg.nursery_on && cadence)) begin
            nxt.old_bytes_at_full = total_sat;
            nxt.alloc_counter     = '0;
          end
        end
      end
      OP_AFTER_MINOR: begin
        if (!cfg.collect_disabled && reached) begin
          nxt.old_bytes_at_full = cur.old_bytes_total;
          action                = ACT_FULL_PROMO;
        end
      end
      OP_ALLOC_FAIL: begin
        nxt.old_bytes_at_full = cur.old_bytes_total;
        nxt.alloc_counter     = '0;
        action                = ACT_FULL_FAIL;
      end
      OP_SET_FOOTPRINT: begin
        nxt.footprint_at_full = footprint_bytes;
      end
      default: begin
        nxt    = cur;
        action = ACT_NONE;
      end
    endcase
  end

endmodule

/* sv/gc_collection_trigger_policy.sv */
// top level of the gc collection trigger policy: ports, registers, config
`timescale 1ns / 1ps
// an event is taken into the input register, and its result is then held in the result register
// one event per cycle unless the result stalls; decision path: one 40x10-bit multiply and compare
// a stalled result holds in the result register while the next event waits in the input register
// reset: synchronous, clears byte counters, allocation count and footprint; registers go
// to disabled=0, nursery_on=1, every_n=0, growth_percent=50; no words are held after reset

module gc_collection_trigger_policy import gcct_pkg::*; #(
  parameter longint unsigned ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // event words in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [87:0]           s_tdata,   // op[2:0], alloc_bytes[42:3], footprint_bytes[82:43]
  // decision words out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // action[2:0]
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               in_valid;
  logic [OP_W-1:0]    in_op;
  logic [BYTES_W-1:0] in_alloc_bytes;
  logic [BYTES_W-1:0] in_footprint_bytes;
  logic               advance;
  gc_cfg_t            cfg;
  gc_state_t          state;
  gc_state_t          state_next;
  action_t            action_next;
  action_t            action;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(8 - ACT_W){1'b0}}, action};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op              <= s_tdata[2:0];
      in_alloc_bytes     <= s_tdata[42:3];
      in_footprint_bytes <= s_tdata[82:43];
    end
  end

  // decision logic
  gcct_decide #(
    .ARENA_BYTES(ARENA_BYTES)
  ) u_decide (
    .op             (op_t'(in_op)),
    .alloc_bytes    (in_alloc_bytes),
    .footprint_bytes(in_footprint_bytes),
    .cfg            (cfg),
    .cur            (state),
    .nxt            (state_next),
    .action         (action_next)
  );

  // policy state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      action <= action_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.collect_disabled <= 1'b0;
      cfg.nursery_on       <= 1'b1;
      cfg.every_n_allocs   <= '0;
      cfg.growth_percent   <= PCT_FALLBACK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLLECT_DISABLED: cfg.collect_disabled <= cfg_data[0];
        CFG_NURSERY_ON:       cfg.nursery_on       <= cfg_data[0];
        CFG_EVERY_N_ALLOCS:   cfg.every_n_allocs   <= cfg_data[CNT_W-1:0];
        CFG_GROWTH_PERCENT:   cfg.growth_percent   <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // baseline never passes the running total
  a_baseline_le_total: assert property (@(posedge clk) disable iff (rst)
    state.old_bytes_at_full <= state.old_bytes_total)
    else $error("old_bytes_at_full above old_bytes_total");

  // allocation failure always forces a full collection and rebases
  a_fail_full: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_ALLOC_FAIL) |=>
      (action == ACT_FULL_FAIL && state.alloc_counter == '0 &&
       state.old_bytes_at_full == state.old_bytes_total))
    else $error("allocation failure did not force a full collection");

  // disabled mode gives no decision other than the failure one
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.collect_disabled && in_op != OP_ALLOC_FAIL) |=> (action == ACT_NONE))
    else $error("collection decided while disabled");

  // input side stalls only with a word held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a held word");

endmodule

/* verif/tb_top.sv */
// testbench for the gc collection trigger policy: predicted decisions checked word by word
`timescale 1ns / 1ps

module tb_top;
  import gcct_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_CYCLES     = 60;
  localparam int SETTLE_CYCLES   = 8;
  localparam logic [39:0] BYTES_ALL_ONES = '1;
  // register index outside the list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;
  // event codes outside the list, must be ignored
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [87:0]           s_tdata   = '0;   // op[2:0], alloc_bytes[42:3], footprint_bytes[82:43]
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [7:0]            m_tdata;          // action[2:0]
  wire                   cfg_ready;

  gc_collection_trigger_policy dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // policy predictor plus the queue of decisions still owed by the block
  class decision_scoreboard;
    logic [BYTES_W-1:0] bytes_total;
    logic [BYTES_W-1:0] bytes_at_full;
    logic [BYTES_W-1:0] footprint;
    logic [CNT_W-1:0]   alloc_count;
    logic               disabled;
    logic               nursery;
    logic [CNT_W-1:0]   cadence;
    logic [PCT_W-1:0]   pct;
    action_t            owed[$];
    int                 errors;

    function new();
      bytes_total   = '0;
      bytes_at_full = '0;
      footprint     = '0;
      alloc_count   = '0;
      disabled      = 1'b0;
      nursery       = 1'b1;
      cadence       = '0;
      pct           = PCT_W'(50);
      errors        = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COLLECT_DISABLED: disabled = data[0];
        CFG_NURSERY_ON:       nursery  = data[0];
        CFG_EVERY_N_ALLOCS:   cadence  = data[CNT_W-1:0];
        CFG_GROWTH_PERCENT:   pct      = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // growth since the last full collection against max(footprint*pct/100, two arenas)
    function bit growth_due();
      logic [BYTES_W-1:0] growth;
      logic [PCT_W-1:0]   p;
      logic [63:0]        limit;
      growth = (bytes_total >= bytes_at_full) ? bytes_total - bytes_at_full : '0;
      p = (pct != '0) ? pct : PCT_FALLBACK;
      limit = 64'(footprint) * 64'(p) / 64'd100;
      if (limit < 64'(2 * ARENA_BYTES_DEF)) limit = 64'(2 * ARENA_BYTES_DEF);
      return 64'(growth) >= limit;
    endfunction

    function bit cadence_hit();
      return cadence != '0 && cadence == alloc_count;
    endfunction

    function void note_event(logic [OP_W-1:0] op, logic [BYTES_W-1:0] ab,
                             logic [BYTES_W-1:0] fb);
      action_t          act;
      logic [BYTES_W:0] sum;
      act = ACT_NONE;
      case (op)
        OP_YOUNG_ALLOC: begin
          alloc_count = alloc_count + 1'b1;
          if (!disabled && cadence_hit()) begin
            alloc_count = '0;
            act = ACT_MINOR_EVERYN;
          end
        end
        OP_OLD_ALLOC: begin
          alloc_count = alloc_count + 1'b1;
          // byte total saturates at the top of its range
          sum = {1'b0, bytes_total} + {1'b0, ab};
          bytes_total = sum[BYTES_W] ? BYTES_ALL_ONES : sum[BYTES_W-1:0];
          if (!disabled) begin
            if (growth_due()) act = ACT_FULL_GROWTH;
            else if (!nursery && cadence_hit()) act = ACT_FULL_EVERYN;
            if (act != ACT_NONE) begin
              bytes_at_full = bytes_total;
              alloc_count = '0;
            end
          end
        end
        OP_AFTER_MINOR: begin
          if (!disabled && growth_due()) begin
            bytes_at_full = bytes_total;
            act = ACT_FULL_PROMO;
          end
        end
        OP_ALLOC_FAIL: begin
          bytes_at_full = bytes_total;
          alloc_count = '0;
          act = ACT_FULL_FAIL;
        end
        OP_SET_FOOTPRINT: footprint = fb;
        default: ;
      endcase
      owed.push_back(act);
    endfunction

    function void check_decision(logic [ACT_W-1:0] got);
      action_t want;
      if (owed.size() == 0) begin
        $error("action: expected nothing, actual %0d", got);
        errors++;
      end else begin
        want = owed.pop_front();
        if (got !== want) begin
          $error("action: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int close_out();
      while (owed.size() != 0) begin
        $error("action: expected %0d, actual none", owed.pop_front());
        errors++;
      end
      return errors;
    endfunction
  endclass

  decision_scoreboard sb;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_request  = 1'b0;
  logic hold_rx       = 1'b0;

  // per-phase register settings; -1 in the percent table means random
  bit          dis_tab     [PHASES] = '{0, 0, 1, 0, 0, 0, 0, 1};
  bit          nursery_tab [PHASES] = '{1, 0, 0, 0, 1, 0, 1, 1};
  int unsigned cadence_tab [PHASES] = '{5, 7, 3, 0, 32'h7FFF_FFFF, 1, 0, 4};
  int          pct_tab     [PHASES] = '{50, 1, 1000, 0, 100, -1, -1, 50};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off once asked for
  always @(posedge clk) begin
    if (rst || hold_rx) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_decision(m_tdata[ACT_W-1:0]);
  end

  // offer one event word, leaving valid high once it is taken
  task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] ab,
                            input logic [BYTES_W-1:0] fb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, fb, ab, op};
    do @(posedge clk); while (!s_tready);
    sb.note_event(op, ab, fb);
  endtask

  // register write, valid stays high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic wait_for_decisions();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [OP_W-1:0]    op;
    logic [BYTES_W-1:0] ab;
    logic [BYTES_W-1:0] fb;
    int                 r;
    int                 pct_val;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset values with junk in the unused upper bits, plus an ignored index
    cfg_write(CFG_UNUSED_IDX, '1);
    cfg_write(CFG_COLLECT_DISABLED, {30'($urandom), 1'b0});
    cfg_write(CFG_NURSERY_ON, {30'($urandom), 1'b1});
    cfg_write(CFG_EVERY_N_ALLOCS, '0);
    cfg_write(CFG_GROWTH_PERCENT, {21'($urandom), 10'd50});
    cfg_valid <= 1'b0;

    // directed: floor threshold, footprint threshold, promotion, failure, ignored codes
    send_event(OP_YOUNG_ALLOC, BYTES_ALL_ONES, BYTES_ALL_ONES);
    send_event(OP_OLD_ALLOC, '0, '0);
    send_event(OP_OLD_ALLOC, 40'd2097151, '0);
    send_event(OP_OLD_ALLOC, 40'd1, '0);
    send_event(OP_AFTER_MINOR, '0, '0);
    send_event(OP_SET_FOOTPRINT, '0, 40'd10485760);
    send_event(OP_OLD_ALLOC, 40'd4194304, '0);
    send_event(OP_SET_FOOTPRINT, '0, '0);
    send_event(OP_AFTER_MINOR, '0, '0);
    send_event(OP_AFTER_MINOR, '0, '0);
    send_event(OP_ALLOC_FAIL, BYTES_ALL_ONES, BYTES_ALL_ONES);
    send_event(OP_UNUSED_LO, BYTES_ALL_ONES, BYTES_ALL_ONES);
    send_event(OP_UNUSED_LO + 3'd1, BYTES_ALL_ONES, BYTES_ALL_ONES);
    send_event(OP_UNUSED_HI, BYTES_ALL_ONES, BYTES_ALL_ONES);
    send_event(OP_SET_FOOTPRINT, '0, BYTES_ALL_ONES);
    send_event(OP_OLD_ALLOC, 40'd3145728, '0);
    send_event(OP_AFTER_MINOR, '0, '0);
    send_event(OP_SET_FOOTPRINT, '0, 40'd4194304);
    send_event(OP_AFTER_MINOR, '0, '0);

    // random phases, each with its own settings and idling mode
    for (int p = 0; p < PHASES; p++) begin
      wait_for_decisions();
      pct_val = (pct_tab[p] < 0) ? $urandom_range(0, 1023) : pct_tab[p];
      cfg_write(CFG_COLLECT_DISABLED, {30'($urandom), dis_tab[p]});
      cfg_write(CFG_NURSERY_ON, {30'($urandom), nursery_tab[p]});
      cfg_write(CFG_EVERY_N_ALLOCS,
                31'((p == 6) ? $urandom_range(1, 12) : cadence_tab[p]));
      cfg_write(CFG_GROWTH_PERCENT, {21'($urandom), 10'(pct_val)});
      cfg_valid <= 1'b0;
      send_idle_pct = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 17 : 0;
      stall_pct <= (p % 4 == 2) ? 72 : (p % 4 == 3) ? 17 : 0;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 4 && i == 20) hold_request <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 30) op = OP_YOUNG_ALLOC;
        else if (r < 62) op = OP_OLD_ALLOC;
        else if (r < 77) op = OP_AFTER_MINOR;
        else if (r < 82) op = OP_ALLOC_FAIL;
        else if (r < 93) op = OP_SET_FOOTPRINT;
        else op = OP_UNUSED_LO + 3'($urandom_range(0, OP_UNUSED_HI - OP_UNUSED_LO));
        // unused fields carry junk so every bit toggles
        ab = BYTES_W'({$urandom, $urandom});
        fb = BYTES_W'({$urandom, $urandom});
        // allocation sizes stay well below saturation so growth keeps mattering
        if (op == OP_OLD_ALLOC) begin
          r = $urandom_range(0, 99);
          if (r < 65) ab = BYTES_W'($urandom_range(0, 65535));
          else if (r < 90) ab = BYTES_W'($urandom_range(0, 4194304));
          else ab = BYTES_W'($urandom_range(0, 2 ** 30));
        end
        if (op == OP_SET_FOOTPRINT) begin
          r = $urandom_range(0, 99);
          if (r < 45) fb = BYTES_W'($urandom_range(0, 4194304));
          else if (r < 80) fb = BYTES_W'($urandom_range(0, 33554432));
          else if (r < 95) fb = BYTES_W'($urandom_range(0, 2 ** 30));
        end
        send_event(op, ab, fb);
      end
    end

    // saturation last: once pinned at the top the byte total never grows again
    wait_for_decisions();
    cfg_write(CFG_COLLECT_DISABLED, '0);
    cfg_write(CFG_NURSERY_ON, 31'd1);
    cfg_write(CFG_GROWTH_PERCENT, 31'd50);
    cfg_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct <= 0;
    send_event(OP_SET_FOOTPRINT, '0, '0);
    send_event(OP_OLD_ALLOC, BYTES_ALL_ONES, '0);
    send_event(OP_OLD_ALLOC, BYTES_ALL_ONES, '0);
    send_event(OP_OLD_ALLOC, 40'd1, '0);
    send_event(OP_AFTER_MINOR, '0, '0);
    send_event(OP_ALLOC_FAIL, '0, '0);
    send_event(OP_YOUNG_ALLOC, '0, '0);

    wait_for_decisions();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.close_out() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
sv/gcct_pkg.sv
sv/gcct_decide.sv
sv/gc_collection_trigger_policy.sv
verif/tb_top.sv
